// ===== rtl/lprf_pkg.sv =====
// Shared types and codes for the length-prefixed record FIFO.
`timescale 1ns / 1ps
`default_nettype none
package lprf_pkg;

    localparam logic [1:0] MODE_PUSH_HDR  = 2'd0;
    localparam logic [1:0] MODE_PUSH_DATA = 2'd1;
    localparam logic [1:0] MODE_POP       = 2'd2;
    localparam logic [1:0] MODE_PEEK      = 2'd3;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_EMPTY      = 2'd1;
    localparam logic [1:0] STATUS_NO_SPACE   = 2'd2;
    localparam logic [1:0] STATUS_UNEXPECTED = 2'd3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [9:0] length;
        logic [6:0] max_read;
    } item_t;

    typedef struct packed {
        logic [1:0] status;
        logic       byte_valid;
        logic [7:0] data_out;
        logic [9:0] stored_length;
        logic       last;
    } result_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic [9:0] length;
        logic       length_ok;
        logic [6:0] read_count;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WR_HDR,
        ST_HDR_RD,
        ST_HDR_CAP,
        ST_CHECK,
        ST_BYTES
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/lprf_queue.sv =====
// Two-entry first-in first-out queue with valid/ready on both sides.
`timescale 1ns / 1ps
`default_nettype none
module lprf_queue #(
    parameter int WIDTH = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_sel_reg;
    logic             wr_sel_next;
    logic             rd_sel_reg;
    logic             rd_sel_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot_reg[rd_sel_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb
    begin
        wr_sel_next = do_wr ? ~wr_sel_reg : wr_sel_reg;
        rd_sel_next = do_rd ? ~rd_sel_reg : rd_sel_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_sel_reg <= 1'b0;
            rd_sel_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_sel_reg <= wr_sel_next;
            rd_sel_reg <= rd_sel_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_sel_reg] <= in_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/lprf_front.sv =====
// Front end: accepts items, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none
module lprf_front #(
    parameter int HEADER_BYTES = 2,
    parameter int MAX_READ     = 64
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    output logic                 full,
    input  wire lprf_pkg::item_t item,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output lprf_pkg::cmd_t       cmd
);

    lprf_pkg::cmd_t classified;
    logic           q_ready;

    always_comb
    begin
        classified.mode      = item.mode;
        classified.data_byte = item.data_byte;
        classified.length    = item.length;
        // A one-byte header cannot carry a length above 255.
        classified.length_ok = (HEADER_BYTES >= 2) || (item.length[9:8] == 2'b00);
        classified.read_count = (item.max_read > 7'(MAX_READ)) ? 7'(MAX_READ)
                                                               : item.max_read;
    end

    assign full = !q_ready;

    lprf_queue #(
        .WIDTH($bits(lprf_pkg::cmd_t))
    ) u_cmd_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push),
        .in_ready  (q_ready),
        .in_data   (classified),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_data  (cmd)
    );

endmodule
`default_nettype wire

// ===== rtl/lprf_back.sv =====
// Back end: ring memory, pointers and the sequencer that carries out each item.
`timescale 1ns / 1ps
`default_nettype none
module lprf_back #(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    input  wire lprf_pkg::cmd_t cmd,
    output logic                res_valid,
    input  wire logic           res_ready,
    output lprf_pkg::result_t   res
);

    localparam int AW     = $clog2(RING_BYTES);
    localparam int FW     = AW + 1;
    localparam int SW     = ((AW > 11) ? AW : 11) + 1;
    localparam int HI_W   = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
    // Only the two low header bytes can be non-zero for a ten-bit length.
    localparam int HB_USE = (HEADER_BYTES > 2) ? 2 : HEADER_BYTES;

    logic [7:0] ring_mem [RING_BYTES];
    logic [7:0] mem_q;

    lprf_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW-1:0]     wp_reg, wp_next;
    logic [FW-1:0]     free_reg, free_next;
    logic [9:0]        left_reg, left_next;
    logic [9:0]        stored_reg, stored_next;
    logic [6:0]        n_reg, n_next;
    logic [6:0]        k_reg, k_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [HI_W-1:0]   hidx_reg, hidx_next;
    lprf_pkg::cmd_t    cmd_reg, cmd_next;
    logic              res_valid_reg, res_valid_next;
    lprf_pkg::result_t res_reg, res_next;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;

    logic              slot_free;
    logic [SW-1:0]     need;
    logic [SW-1:0]     span;
    logic [SW-1:0]     occupied;
    logic [SW-1:0]     free_sum;
    logic [6:0]        n_calc;
    logic [AW-1:0]     start_addr;

    function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        begin
            r = (s >= SW'(RING_BYTES)) ? s - SW'(RING_BYTES) : s;
            return r[AW-1:0];
        end
    endfunction

    function automatic lprf_pkg::result_t make_res(input logic [1:0] status,
                                                   input logic       bv,
                                                   input logic [7:0] b,
                                                   input logic [9:0] len,
                                                   input logic       lst);
        lprf_pkg::result_t r;
        begin
            r.status        = status;
            r.byte_valid    = bv;
            r.data_out      = b;
            r.stored_length = len;
            r.last          = lst;
            return r;
        end
    endfunction

    assign res_valid  = res_valid_reg;
    assign res        = res_reg;
    assign slot_free  = !res_valid_reg || res_ready;
    assign cmd_ready  = (state_reg == lprf_pkg::ST_IDLE) && slot_free;

    assign need       = SW'(HEADER_BYTES) + SW'(cmd.length);
    assign span       = SW'(HEADER_BYTES) + SW'(stored_reg);
    assign occupied   = SW'(RING_BYTES) - SW'(free_reg);
    assign free_sum   = SW'(free_reg) + span;
    assign n_calc     = ({3'b000, cmd_reg.read_count} > stored_reg) ? stored_reg[6:0]
                                                                   : cmd_reg.read_count;
    assign start_addr = wrap_sum(SW'(rp_reg) + SW'(HEADER_BYTES));

    always_comb
    begin
        state_next     = state_reg;
        rp_next        = rp_reg;
        wp_next        = wp_reg;
        free_next      = free_reg;
        left_next      = left_reg;
        stored_next    = stored_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        hidx_next      = hidx_reg;
        cmd_next       = cmd_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = wp_reg;
        wr_data        = 8'd0;
        rd_en          = 1'b0;
        rd_addr        = addr_reg;

        case (state_reg)
            lprf_pkg::ST_IDLE:
            begin
                if (cmd_valid && slot_free)
                begin
                    cmd_next = cmd;
                    case (cmd.mode)
                        lprf_pkg::MODE_PUSH_HDR:
                        begin
                            res_valid_next = 1'b1;
                            if (left_reg != 10'd0)
                            begin
                                res_next = make_res(lprf_pkg::STATUS_UNEXPECTED, 1'b0,
                                                    8'd0, 10'd0, 1'b1);
                            end
                            else if (!cmd.length_ok || (need > SW'(free_reg)))
                            begin
                                res_next = make_res(lprf_pkg::STATUS_NO_SPACE, 1'b0,
                                                    8'd0, 10'd0, 1'b1);
                            end
                            else
                            begin
                                res_next   = make_res(lprf_pkg::STATUS_OK, 1'b0,
                                                      8'd0, 10'd0, 1'b1);
                                free_next  = free_reg - need[FW-1:0];
                                left_next  = cmd.length;
                                hidx_next  = '0;
                                state_next = lprf_pkg::ST_WR_HDR;
                            end
                        end
                        lprf_pkg::MODE_PUSH_DATA:
                        begin
                            res_valid_next = 1'b1;
                            if (left_reg == 10'd0)
                            begin
                                res_next = make_res(lprf_pkg::STATUS_UNEXPECTED, 1'b0,
                                                    8'd0, 10'd0, 1'b1);
                            end
                            else
                            begin
                                res_next  = make_res(lprf_pkg::STATUS_OK, 1'b0,
                                                     8'd0, 10'd0, 1'b1);
                                wr_en     = 1'b1;
                                wr_data   = cmd.data_byte;
                                wp_next   = wrap_sum(SW'(wp_reg) + SW'(1));
                                left_next = left_reg - 10'd1;
                            end
                        end
                        default:
                        begin
                            if (free_reg == FW'(RING_BYTES))
                            begin
                                res_valid_next = 1'b1;
                                res_next = make_res(lprf_pkg::STATUS_EMPTY, 1'b0,
                                                    8'd0, 10'd0, 1'b1);
                            end
                            else
                            begin
                                stored_next = 10'd0;
                                hidx_next   = '0;
                                state_next  = lprf_pkg::ST_HDR_RD;
                            end
                        end
                    endcase
                end
            end

            lprf_pkg::ST_WR_HDR:
            begin
                wr_en = 1'b1;
                if (hidx_reg == HI_W'(0))
                begin
                    wr_data = cmd_reg.length[7:0];
                end
                else if (hidx_reg == HI_W'(1))
                begin
                    wr_data = {6'd0, cmd_reg.length[9:8]};
                end
                wp_next = wrap_sum(SW'(wp_reg) + SW'(1));
                if (hidx_reg == HI_W'(HEADER_BYTES - 1))
                begin
                    state_next = lprf_pkg::ST_IDLE;
                end
                else
                begin
                    hidx_next = hidx_reg + HI_W'(1);
                end
            end

            lprf_pkg::ST_HDR_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = wrap_sum(SW'(rp_reg) + SW'(hidx_reg));
                state_next = lprf_pkg::ST_HDR_CAP;
            end

            lprf_pkg::ST_HDR_CAP:
            begin
                if (hidx_reg == HI_W'(0))
                begin
                    stored_next[7:0] = mem_q;
                end
                else
                begin
                    stored_next[9:8] = mem_q[1:0];
                end
                if (hidx_reg == HI_W'(HB_USE - 1))
                begin
                    state_next = lprf_pkg::ST_CHECK;
                end
                else
                begin
                    hidx_next  = hidx_reg + HI_W'(1);
                    state_next = lprf_pkg::ST_HDR_RD;
                end
            end

            lprf_pkg::ST_CHECK:
            begin
                if (slot_free)
                begin
                    // The head record is the one still being filled.
                    if ((left_reg != 10'd0) && (occupied == span))
                    begin
                        res_valid_next = 1'b1;
                        res_next = make_res(lprf_pkg::STATUS_EMPTY, 1'b0,
                                            8'd0, 10'd0, 1'b1);
                        state_next = lprf_pkg::ST_IDLE;
                    end
                    else if (n_calc == 7'd0)
                    begin
                        res_valid_next = 1'b1;
                        res_next = make_res(lprf_pkg::STATUS_OK, 1'b0,
                                            8'd0, stored_reg, 1'b1);
                        state_next = lprf_pkg::ST_IDLE;
                        if (cmd_reg.mode == lprf_pkg::MODE_POP)
                        begin
                            rp_next   = wrap_sum(SW'(rp_reg) + span);
                            free_next = (free_sum > SW'(RING_BYTES)) ? FW'(RING_BYTES)
                                                                     : free_sum[FW-1:0];
                        end
                    end
                    else
                    begin
                        n_next     = n_calc;
                        k_next     = 7'd0;
                        rd_en      = 1'b1;
                        rd_addr    = start_addr;
                        addr_next  = wrap_sum(SW'(start_addr) + SW'(1));
                        state_next = lprf_pkg::ST_BYTES;
                    end
                end
            end

            lprf_pkg::ST_BYTES:
            begin
                if (slot_free)
                begin
                    res_valid_next = 1'b1;
                    res_next = make_res(lprf_pkg::STATUS_OK, 1'b1, mem_q, stored_reg,
                                        (k_reg + 7'd1) == n_reg);
                    if ((k_reg + 7'd1) == n_reg)
                    begin
                        state_next = lprf_pkg::ST_IDLE;
                        if (cmd_reg.mode == lprf_pkg::MODE_POP)
                        begin
                            rp_next   = wrap_sum(SW'(rp_reg) + span);
                            free_next = (free_sum > SW'(RING_BYTES)) ? FW'(RING_BYTES)
                                                                     : free_sum[FW-1:0];
                        end
                    end
                    else
                    begin
                        // Fetch the next byte while this one goes out.
                        rd_en     = 1'b1;
                        rd_addr   = addr_reg;
                        addr_next = wrap_sum(SW'(addr_reg) + SW'(1));
                        k_next    = k_reg + 7'd1;
                    end
                end
            end

            default:
            begin
                state_next = lprf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lprf_pkg::ST_IDLE;
            rp_reg        <= '0;
            wp_reg        <= '0;
            free_reg      <= FW'(RING_BYTES);
            left_reg      <= 10'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            free_reg      <= free_next;
            left_reg      <= left_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stored_reg <= stored_next;
        n_reg      <= n_next;
        k_reg      <= k_next;
        addr_reg   <= addr_next;
        hidx_reg   <= hidx_next;
        cmd_reg    <= cmd_next;
        res_reg    <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= ring_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/length_prefixed_record_fifo.sv =====
// Top level of the length-prefixed record FIFO.
`timescale 1ns / 1ps
`default_nettype none
// Records live in a single-port-write, registered-read byte ring of RING_BYTES
// entries, each as a HEADER_BYTES little-endian length followed by its bytes.
// Items enter a two-entry command queue (full/push) and results leave through a
// two-entry result queue (empty/pop), so either side may stall on its own. The
// sequencer takes one item at a time: a push data byte is written as it is
// accepted; a push header is accepted, then written one header byte at a time;
// a pop or peek is accepted, reads and captures min(HEADER_BYTES,2) length
// bytes, checks the header, then returns one byte per cycle while the result
// path has room (up to MAX_READ). A rejected push or an empty-ring answer comes
// straight from the idle state; a pop or peek that finds only a record still
// being filled answers after the header check. Ring memory is never reset.
module length_prefixed_record_fifo #(
    parameter int RING_BYTES   = 1024,
    parameter int HEADER_BYTES = 2,
    parameter int MAX_READ     = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire lprf_pkg::item_t   item,
    output logic                   empty,
    input  wire logic              pop,
    output lprf_pkg::result_t      result
);

    lprf_pkg::cmd_t    cmd;
    logic              cmd_valid;
    logic              cmd_ready;
    lprf_pkg::result_t res;
    logic              res_valid;
    logic              res_ready;
    logic              out_valid;

    lprf_front #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_READ     (MAX_READ)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    lprf_back #(
        .RING_BYTES   (RING_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    lprf_queue #(
        .WIDTH($bits(lprf_pkg::result_t))
    ) u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (res_ready),
        .in_data   (res),
        .out_valid (out_valid),
        .out_ready (pop),
        .out_data  (result)
    );

    assign empty = !out_valid;

endmodule
`default_nettype wire
